[hdl/dar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dar_pkg;

	// operation codes
	localparam logic OP_QUERY  = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// query answers
	localparam logic [1:0] VERDICT_UNSETTLED = 2'd0;
	localparam logic [1:0] VERDICT_ALIVE     = 2'd1;
	localparam logic [1:0] VERDICT_DEAD      = 2'd2;

	// fixed part of the key: 32-bit hash plus the question flag
	localparam int KEY_FIXED_BITS = 33;

	// controller to datapath
	typedef struct packed {
		logic clear_wr;  // clear one valid bit of the sweep
		logic load;      // capture the transaction and read the table
		logic resolve;   // compare, answer or write back
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;  // sweep is at its last entry
		logic is_query;    // held transaction is a lookup
	} sts_t;

endpackage

`default_nettype wire

[hdl/dar_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module dar_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire dar_pkg::sts_t sts,
	output dar_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESOLVE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// commands follow the state
	always_comb begin
		cmd          = '0;
		cmd.clear_wr = (state_q == ST_CLEAR);
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.resolve  = (state_q == ST_RESOLVE);
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RESOLVE;
						busy_q  <= 1'b1;
					end
				end
				ST_RESOLVE: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= sts.is_query;
				end
				default: begin
					state_q <= ST_CLEAR;
					busy_q  <= 1'b1;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	// busy flag tracks the state
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != ST_IDLE))
		else $error("busy flag out of step with state");

	// an accepted transaction is resolved in the next cycle
	a_accept_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> (state_q == ST_RESOLVE))
		else $error("accepted transaction not resolved");

	// a result only follows a resolve cycle of a lookup
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_RESOLVE && $past(sts.is_query)))
		else $error("result without a resolved lookup");

	// the sweep ends in idle
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear_wr && sts.clear_last) |=> !busy_q)
		else $error("sweep did not end in idle");

endmodule

`default_nettype wire

[hdl/dar_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module dar_datapath #(
	parameter int INDEX_BITS  = 12,
	parameter int TARGET_BITS = 9,
	parameter int DEPTH_BITS  = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dar_pkg::cmd_t          cmd,
	output dar_pkg::sts_t               sts,
	input  wire logic                   op,
	input  wire logic [31:0]            position_hash,
	input  wire logic [TARGET_BITS-1:0] target,
	input  wire logic                   want_capture,
	input  wire logic [DEPTH_BITS-1:0]  search_depth,
	input  wire logic                   outcome,
	output logic [1:0]                  verdict
);

	localparam int KEY_BITS = dar_pkg::KEY_FIXED_BITS + TARGET_BITS;
	localparam int ENTRIES  = 1 << INDEX_BITS;

	// table storage
	logic                  vld_mem [ENTRIES];
	logic [KEY_BITS-1:0]   key_mem [ENTRIES];
	logic [DEPTH_BITS-1:0] val_mem [ENTRIES];

	logic [INDEX_BITS-1:0] clr_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [KEY_BITS-1:0]   key_q;
	logic                  op_q;
	logic                  capture_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic                  vld_rd_q;
	logic [KEY_BITS-1:0]   key_rd_q;
	logic [DEPTH_BITS-1:0] val_rd_q;
	logic [1:0]            verdict_q;

	logic [31:0]           mix;
	logic [INDEX_BITS-1:0] idx_in;
	logic [KEY_BITS-1:0]   key_in;
	logic                  hit;
	logic                  deeper_ask;
	logic                  wr_en;
	logic [DEPTH_BITS-1:0] wr_val;

	// index and key of the incoming transaction
	always_comb begin
		mix    = position_hash ^ {{(31 - TARGET_BITS){1'b0}}, target, 1'b0}
			^ {31'd0, want_capture};
		idx_in = mix[INDEX_BITS-1:0];
		key_in = {want_capture, target, position_hash};
	end

	// clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// capture transaction fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q     <= idx_in;
			key_q     <= key_in;
			op_q      <= op;
			capture_q <= (outcome == want_capture);
			depth_q   <= search_depth;
		end
	end

	// table read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vld_rd_q <= vld_mem[idx_in];
			key_rd_q <= key_mem[idx_in];
			val_rd_q <= val_mem[idx_in];
		end
	end

	// hit test and write-back decision
	always_comb begin
		hit        = vld_rd_q && (key_rd_q == key_q);
		deeper_ask = (val_rd_q < depth_q);
		wr_en      = cmd.resolve && (op_q == dar_pkg::OP_INSERT)
			&& (capture_q || !hit || deeper_ask);
		wr_val     = capture_q ? '0 : depth_q;
	end

	// valid bits: cleared by the sweep, set on insert
	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			vld_mem[clr_q] <= 1'b0;
		end else if (wr_en) begin
			vld_mem[idx_q] <= 1'b1;
		end
	end

	// key and value write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[idx_q] <= key_q;
			val_mem[idx_q] <= wr_val;
		end
	end

	// lookup answer
	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			if (!hit) begin
				verdict_q <= dar_pkg::VERDICT_UNSETTLED;
			end else if (val_rd_q == '0) begin
				verdict_q <= dar_pkg::VERDICT_DEAD;
			end else if (!deeper_ask) begin
				verdict_q <= dar_pkg::VERDICT_ALIVE;
			end else begin
				verdict_q <= dar_pkg::VERDICT_UNSETTLED;
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.clear_last = &clr_q;
		sts.is_query   = (op_q == dar_pkg::OP_QUERY);
	end

	assign verdict = verdict_q;

endmodule

`default_nettype wire

[hdl/depth_aware_result_cache_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Depth-preferred result cache, direct mapped with 2^INDEX_BITS entries and
// full key tags. After reset the block sweeps all 2^INDEX_BITS valid bits
// (4096 at the default size) with busy high. A transaction is taken when
// start is high and busy is low; it then has a load step that reads the
// table entry and a resolve step that compares and writes back. A lookup
// answers on verdict with done high for exactly one cycle, the cycle after
// its resolve step; an insert gives no result. The receiver cannot stall:
// each result must be taken in the cycle it appears. A new transaction may
// be started in the same cycle as done.
module depth_aware_result_cache_core #(
	parameter int INDEX_BITS  = 12,
	parameter int TARGET_BITS = 9,
	parameter int DEPTH_BITS  = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   op,
	input  wire logic [31:0]            position_hash,
	input  wire logic [TARGET_BITS-1:0] target,
	input  wire logic                   want_capture,
	input  wire logic [DEPTH_BITS-1:0]  search_depth,
	input  wire logic                   outcome,
	output logic                        done,
	output logic [1:0]                  verdict
);

	dar_pkg::cmd_t cmd;
	dar_pkg::sts_t sts;

	dar_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dar_datapath #(
		.INDEX_BITS  (INDEX_BITS),
		.TARGET_BITS (TARGET_BITS),
		.DEPTH_BITS  (DEPTH_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.position_hash (position_hash),
		.target        (target),
		.want_capture  (want_capture),
		.search_depth  (search_depth),
		.outcome       (outcome),
		.verdict       (verdict)
	);

endmodule

`default_nettype wire
